// ----- rtl/core/zclx_pkg.sv -----
// Package for the zero crossing lobe extractor: field widths, register indexes,
// reset values, sequencer state type and the area saturation function.
// No dependencies.
package zclx_pkg;

	localparam int SAMPLE_WIDTH_DEF = 24;

	localparam int AREA_W  = 48;
	localparam int TIME_W  = 32;
	localparam int GAP_W   = 24;
	localparam int STEP_W  = 47;
	localparam int SPS_W   = 40;
	localparam int CFG_W   = 47;
	localparam int CIDX_W  = 2;

	localparam int WIDE_W  = 52;
	localparam int MUL_A_W = 64;
	localparam int CHUNK_W = 16;
	localparam int ACC_W   = MUL_A_W + CHUNK_W;
	localparam int Q_W     = 51;

	localparam logic [CIDX_W-1:0] REG_STEREO_MODE    = 2'd0;
	localparam logic [CIDX_W-1:0] REG_MIN_GAP_TICKS  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_MIN_STEP       = 2'd2;
	localparam logic [CIDX_W-1:0] REG_SEC_PER_SAMPLE = 2'd3;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	localparam logic              RST_STEREO_MODE    = 1'b0;
	localparam logic [GAP_W-1:0]  RST_MIN_GAP_TICKS  = 24'd0;
	localparam logic [STEP_W-1:0] RST_MIN_STEP       = 47'd84;
	localparam logic [SPS_W-1:0]  RST_SEC_PER_SAMPLE = 40'd24932236;

	localparam logic [MUL_A_W-1:0] ROUND_ADD = 64'h0000_00FF_FFFF_FFFF;
	localparam logic [Q_W-1:0]     Q_LIMIT   = 51'h4_0000_0000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_CROSS,
		ST_MUL,
		ST_MERGE_C,
		ST_MERGE_ADD,
		ST_EMIT
	} state_t;

	function automatic logic signed [AREA_W-1:0] sat_area(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(signed'(48'sh7FFF_FFFF_FFFF));
		lo = WIDE_W'(signed'(48'sh8000_0000_0000));
		if (v > hi) begin
			sat_area = 48'sh7FFF_FFFF_FFFF;
		end else if (v < lo) begin
			sat_area = 48'sh8000_0000_0000;
		end else begin
			sat_area = v[AREA_W-1:0];
		end
	endfunction

endpackage

// ----- rtl/core/zero_crossing_lobe_extractor_top.sv -----
// Top level of the zero crossing lobe extractor: sequencer, lobe state and one
// shared 64x16 multiply-accumulate unit. Depends on zclx_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall, op, left_sample, right_sample) takes one
//   item at a time: a sample (op 0) or an end of stream flush (op 1).
//   Output channel (out_valid/out_stall, entry_time, entry_area, final_res)
//   carries emitted entries from an output register.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   stereo_mode, min_gap_ticks, min_step, sec_per_sample; always ready. Write
//   only while the block is idle.
// Timing:
//   in_stall is high while the sequencer works on an item. Items pass ST_SUM,
//   final for a sample without a crossing or a flush with no entry; a first or
//   dropped crossing adds ST_CROSS, a flush with an entry ST_EMIT, a replacing
//   crossing ST_CROSS, ST_EMIT, a merge ST_CROSS, ST_MUL (five multiplier
//   passes: two for gap * sec_per_sample, three for the lobe product),
//   ST_MERGE_C, ST_MERGE_ADD. An entry is output the cycle after ST_EMIT.
// Stall: an emit waits while the output register holds an item under stall.
// Reset: arst_n clears all lobe state and loads the configuration defaults.
module zero_crossing_lobe_extractor_top #(
	parameter int SAMPLE_WIDTH = zclx_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               op,
	input  logic signed [SAMPLE_WIDTH-1:0]     left_sample,
	input  logic signed [SAMPLE_WIDTH-1:0]     right_sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [zclx_pkg::TIME_W-1:0]        entry_time,
	output logic signed [zclx_pkg::AREA_W-1:0] entry_area,
	output logic                               final_res,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [zclx_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [zclx_pkg::CFG_W-1:0]         cfg_data
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int AW = zclx_pkg::AREA_W;
	localparam int TW = zclx_pkg::TIME_W;
	localparam int WW = zclx_pkg::WIDE_W;
	localparam int CW = zclx_pkg::CHUNK_W;
	localparam int MW = zclx_pkg::MUL_A_W;
	localparam int XW = zclx_pkg::ACC_W;
	localparam int QW = zclx_pkg::Q_W;

	zclx_pkg::state_t state_q, state_d;

	logic                          stereo_mode_q;
	logic [zclx_pkg::GAP_W-1:0]    min_gap_q;
	logic [zclx_pkg::STEP_W-1:0]   min_step_q;
	logic [zclx_pkg::SPS_W-1:0]    sps_q;

	logic signed [AW-1:0]          lobe_sum_q;
	logic signed [SW-1:0]          prev_sample_q;
	logic [TW-1:0]                 tick_q;
	logic                          have_entry_q;
	logic [TW-1:0]                 pend_time_q;
	logic signed [AW-1:0]          pend_area_q;

	logic                          op_q;
	logic signed [SW-1:0]          left_q;
	logic signed [SW-1:0]          right_q;
	logic signed [AW-1:0]          lobe_q;
	logic [TW-1:0]                 gap_q;
	logic [TW-1:0]                 cross_tick_q;
	logic signed [AW-1:0]          contrib_q;
	logic [MW-1:0]                 mul_a_q;
	logic [AW-1:0]                 mul_b_q;
	logic [MW-1:0]                 acc_hi_q;
	logic [AW-1:0]                 acc_lo_q;
	logic [1:0]                    cnt_q;
	logic                          phase_q;
	logic                          out_valid_q;

	logic signed [SW:0]            pair_sum;
	logic signed [SW-1:0]          sample_s;
	logic signed [AW-1:0]          lobe_new;
	logic                          crossing;
	logic                          out_free;
	logic                          in_accept;
	logic                          do_merge;
	logic                          do_replace;
	logic signed [AW:0]            diff;
	logic [AW:0]                   diff_mag;
	logic                          lobe_neg;
	logic [AW-1:0]                 lobe_mag;
	logic [XW-1:0]                 mul_t;
	logic [MW-1:0]                 hi_next;
	logic [AW-1:0]                 lo_next;
	logic [MW-1:0]                 p_prod;
	logic                          mul_last;
	logic [QW-1:0]                 q_mag;
	logic signed [WW-1:0]          q_signed;
	logic signed [WW-1:0]          contrib_wide;

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != zclx_pkg::ST_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign out_free   = !out_valid_q || !out_stall;

	assign pair_sum = {left_q[SW-1], left_q} + {right_q[SW-1], right_q};
	assign sample_s = stereo_mode_q ? pair_sum[SW:1] : left_q;
	assign lobe_new = zclx_pkg::sat_area(WW'(lobe_sum_q) + WW'(sample_s));
	assign crossing = ((sample_s < 0) && (prev_sample_q > 0))
	               || ((sample_s > 0) && (prev_sample_q < 0));

	assign lobe_neg = lobe_q[AW-1];
	assign lobe_mag = lobe_neg ? (-lobe_q) : lobe_q;
	assign do_merge = gap_q < TW'(min_gap_q);
	assign diff     = (AW+1)'(lobe_q) - (AW+1)'(pend_area_q);
	assign diff_mag = diff[AW] ? (-diff) : diff;
	assign do_replace = (((pend_area_q > 0) && (lobe_q < 0)) || ((pend_area_q < 0) && (lobe_q > 0)))
	                 && (diff_mag > (AW+1)'(min_step_q));

	assign mul_t    = mul_a_q * mul_b_q[CW-1:0];
	assign {hi_next, lo_next[AW-1:AW-CW]} = mul_t + XW'(acc_hi_q);
	assign lo_next[AW-CW-1:0] = acc_lo_q[AW-1:CW];
	assign p_prod   = {hi_next[31:0], lo_next[AW-1:CW]};
	assign mul_last = (cnt_q == 2'd0);

	assign q_mag    = (acc_hi_q[MW-1:42] != '0) ? zclx_pkg::Q_LIMIT
	                : QW'({acc_hi_q[41:0], acc_lo_q[AW-1:40]});
	assign q_signed = lobe_neg ? -(WW'(q_mag)) : WW'(q_mag);
	assign contrib_wide = WW'(lobe_q) - q_signed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= zclx_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			zclx_pkg::ST_IDLE: begin
				if (in_accept) state_d = zclx_pkg::ST_SUM;
			end
			zclx_pkg::ST_SUM: begin
				if (op_q == zclx_pkg::OP_FLUSH) begin
					state_d = have_entry_q ? zclx_pkg::ST_EMIT : zclx_pkg::ST_IDLE;
				end else begin
					state_d = crossing ? zclx_pkg::ST_CROSS : zclx_pkg::ST_IDLE;
				end
			end
			zclx_pkg::ST_CROSS: begin
				if (!have_entry_q) state_d = zclx_pkg::ST_IDLE;
				else if (do_merge) state_d = zclx_pkg::ST_MUL;
				else if (do_replace) state_d = zclx_pkg::ST_EMIT;
				else state_d = zclx_pkg::ST_IDLE;
			end
			zclx_pkg::ST_MUL: begin
				if (mul_last && phase_q) state_d = zclx_pkg::ST_MERGE_C;
			end
			zclx_pkg::ST_MERGE_C: begin
				state_d = zclx_pkg::ST_MERGE_ADD;
			end
			zclx_pkg::ST_MERGE_ADD: begin
				state_d = zclx_pkg::ST_IDLE;
			end
			zclx_pkg::ST_EMIT: begin
				if (out_free) state_d = zclx_pkg::ST_IDLE;
			end
			default: begin
				state_d = zclx_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_mode_q <= zclx_pkg::RST_STEREO_MODE;
			min_gap_q     <= zclx_pkg::RST_MIN_GAP_TICKS;
			min_step_q    <= zclx_pkg::RST_MIN_STEP;
			sps_q         <= zclx_pkg::RST_SEC_PER_SAMPLE;
			lobe_sum_q    <= '0;
			prev_sample_q <= '0;
			tick_q        <= '0;
			have_entry_q  <= 1'b0;
			pend_time_q   <= '0;
			pend_area_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					zclx_pkg::REG_STEREO_MODE:    stereo_mode_q <= cfg_data[0];
					zclx_pkg::REG_MIN_GAP_TICKS:  min_gap_q <= cfg_data[zclx_pkg::GAP_W-1:0];
					zclx_pkg::REG_MIN_STEP:       min_step_q <= cfg_data[zclx_pkg::STEP_W-1:0];
					zclx_pkg::REG_SEC_PER_SAMPLE: sps_q <= cfg_data[zclx_pkg::SPS_W-1:0];
					default: ;
				endcase
			end
			if ((state_q == zclx_pkg::ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				zclx_pkg::ST_SUM: begin
					if (op_q == zclx_pkg::OP_FLUSH) begin
						if (!have_entry_q) begin
							lobe_sum_q    <= '0;
							prev_sample_q <= '0;
							tick_q        <= '0;
							pend_time_q   <= '0;
							pend_area_q   <= '0;
						end
					end else begin
						lobe_sum_q    <= crossing ? '0 : lobe_new;
						prev_sample_q <= sample_s;
						tick_q        <= tick_q + 1'b1;
					end
				end
				zclx_pkg::ST_CROSS: begin
					if (!have_entry_q) begin
						have_entry_q <= 1'b1;
						pend_time_q  <= cross_tick_q;
						pend_area_q  <= lobe_q;
					end
				end
				zclx_pkg::ST_MERGE_ADD: begin
					pend_area_q <= zclx_pkg::sat_area(WW'(pend_area_q) + WW'(contrib_q));
				end
				zclx_pkg::ST_EMIT: begin
					if (out_free) begin
						if (op_q == zclx_pkg::OP_FLUSH) begin
							lobe_sum_q    <= '0;
							prev_sample_q <= '0;
							tick_q        <= '0;
							have_entry_q  <= 1'b0;
							pend_time_q   <= '0;
							pend_area_q   <= '0;
						end else begin
							pend_time_q <= cross_tick_q;
							pend_area_q <= lobe_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			zclx_pkg::ST_IDLE: begin
				if (in_accept) begin
					op_q    <= op;
					left_q  <= left_sample;
					right_q <= right_sample;
				end
			end
			zclx_pkg::ST_SUM: begin
				lobe_q       <= lobe_new;
				gap_q        <= tick_q - pend_time_q;
				cross_tick_q <= tick_q;
			end
			zclx_pkg::ST_CROSS: begin
				mul_a_q  <= MW'(sps_q);
				mul_b_q  <= AW'(gap_q[zclx_pkg::GAP_W-1:0]);
				acc_hi_q <= '0;
				acc_lo_q <= '0;
				cnt_q    <= 2'd1;
				phase_q  <= 1'b0;
			end
			zclx_pkg::ST_MUL: begin
				if (mul_last && !phase_q) begin
					mul_a_q  <= p_prod;
					mul_b_q  <= lobe_mag;
					acc_hi_q <= lobe_neg ? '0 : zclx_pkg::ROUND_ADD;
					acc_lo_q <= '0;
					cnt_q    <= 2'd2;
					phase_q  <= 1'b1;
				end else begin
					acc_hi_q <= hi_next;
					acc_lo_q <= lo_next;
					mul_b_q  <= mul_b_q >> CW;
					cnt_q    <= cnt_q - 1'b1;
				end
			end
			zclx_pkg::ST_MERGE_C: begin
				contrib_q <= zclx_pkg::sat_area(contrib_wide);
			end
			zclx_pkg::ST_EMIT: begin
				if (out_free) begin
					entry_time <= pend_time_q;
					entry_area <= pend_area_q;
					final_res  <= op_q;
				end
			end
			default: ;
		endcase
	end

endmodule
